@@ rtl/mmfc_pkg.sv @@
package mmfc_pkg;

    localparam int MAX_WORDS   = 16;
    localparam int REPLY_BYTES = 64;

    localparam int TCP_BASE    = 6;
    localparam int RTU_MIN_LEN = 6;
    localparam int TCP_MIN_LEN = 9;

    localparam int LIST_IDX_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int LEN_W       = $clog2(MAX_WORDS + 1);
    localparam int RX_ADDR_W   = $clog2(REPLY_BYTES);
    localparam int RX_CNT_W    = $clog2(REPLY_BYTES + 1);
    localparam int RD_SPAN     = TCP_BASE + 4 + 2 * MAX_WORDS;
    localparam int RD_ADDR_W   = ($clog2(RD_SPAN + 1) > RX_CNT_W) ? $clog2(RD_SPAN + 1) : RX_CNT_W;
    localparam int FRAME_K_W   = $clog2(13 + 2 * MAX_WORDS);

    localparam logic [7:0]  FN_READ         = 8'h03;
    localparam logic [7:0]  FN_WRITE_SINGLE = 8'h06;
    localparam logic [7:0]  FN_WRITE_MULTI  = 8'd16;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;

    typedef enum logic [2:0] {
        CMD_CLEAR     = 3'd0,
        CMD_APPEND    = 3'd1,
        CMD_RTU_REQ   = 3'd2,
        CMD_TCP_REQ   = 3'd3,
        CMD_TCP_MULTI = 3'd4,
        CMD_RTU_RX    = 3'd5,
        CMD_TCP_RX    = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_EMPTY = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CFG_SLAVE_ID   = 2'd0,
        CFG_START_ADDR = 2'd1,
        CFG_WRITE_MODE = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        RD_FN,
        RD_BC,
        RD_HI,
        RD_LO
    } rd_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_FRAME,
        S_DEC_FN,
        S_DEC_BC,
        S_DEC_CHK,
        S_DEC_HI,
        S_DEC_LO,
        S_DEC_WR,
        S_DEC_END,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] value_word;
        logic [7:0]  data_byte;
        logic        last_byte;
    } req_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         frame_byte;
        logic signed [15:0] reg_value;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic    req_load;
        logic    list_clear;
        logic    list_append;
        logic    rx_write;
        logic    frame_init;
        logic    frame_emit;
        rd_sel_t rd_sel;
        logic    dec_ok_load;
        logic    dec_start;
        logic    hi_load;
        logic    word_write;
        logic    count_clear;
        logic    emit_empty;
        logic    emit_word;
    } ctl_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       last_byte;
        logic       frame_last;
        logic       dec_more;
        logic       list_empty;
        logic       word_last;
    } stat_t;

endpackage

@@ rtl/mmfc_ctrl.sv @@
module mmfc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  mmfc_pkg::stat_t stat,
    output mmfc_pkg::ctl_t  ctl
);
    import mmfc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (cmd_t'(stat.cmd))
                    CMD_RTU_REQ, CMD_TCP_REQ, CMD_TCP_MULTI:
                    begin
                        state_next = S_FRAME;
                    end
                    CMD_RTU_RX, CMD_TCP_RX:
                    begin
                        state_next = stat.last_byte ? S_DEC_FN : S_IDLE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_FRAME:
            begin
                if (stat.frame_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DEC_FN:  state_next = S_DEC_BC;
            S_DEC_BC:  state_next = S_DEC_CHK;
            S_DEC_CHK: state_next = S_DEC_HI;
            S_DEC_HI:  state_next = stat.dec_more ? S_DEC_LO : S_DEC_END;
            S_DEC_LO:  state_next = S_DEC_WR;
            S_DEC_WR:  state_next = S_DEC_HI;
            S_DEC_END: state_next = stat.list_empty ? S_IDLE : S_EMIT;
            S_EMIT:
            begin
                if (stat.word_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl        = '0;
        ctl.rd_sel = RD_FN;
        case (state_reg)
            S_IDLE:
            begin
                ctl.req_load = start;
            end
            S_EXEC:
            begin
                case (cmd_t'(stat.cmd))
                    CMD_CLEAR:     ctl.list_clear  = 1'b1;
                    CMD_APPEND:    ctl.list_append = 1'b1;
                    CMD_RTU_REQ,
                    CMD_TCP_REQ,
                    CMD_TCP_MULTI: ctl.frame_init  = 1'b1;
                    CMD_RTU_RX,
                    CMD_TCP_RX:    ctl.rx_write    = 1'b1;
                    default:       ctl.list_clear  = 1'b0;
                endcase
            end
            S_FRAME:   ctl.frame_emit = 1'b1;
            S_DEC_FN:  ctl.rd_sel = RD_FN;
            S_DEC_BC:
            begin
                ctl.rd_sel      = RD_BC;
                ctl.dec_ok_load = 1'b1;
            end
            S_DEC_CHK: ctl.dec_start = 1'b1;
            S_DEC_HI:  ctl.rd_sel = RD_HI;
            S_DEC_LO:
            begin
                ctl.rd_sel  = RD_LO;
                ctl.hi_load = 1'b1;
            end
            S_DEC_WR:  ctl.word_write = 1'b1;
            S_DEC_END:
            begin
                ctl.count_clear = 1'b1;
                ctl.emit_empty  = stat.list_empty;
                ctl.frame_init  = !stat.list_empty;
            end
            S_EMIT:    ctl.emit_word = 1'b1;
            default:   ctl.rd_sel = RD_FN;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    a_single_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.list_clear, ctl.list_append, ctl.rx_write, ctl.frame_emit,
                  ctl.emit_word, ctl.emit_empty}))
        else $error("more than one datapath action in a cycle");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> (state_reg == S_EXEC))
        else $error("accepted request did not enter execution");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FRAME && stat.frame_last) |=> !busy)
        else $error("controller did not return to idle after the last frame byte");

endmodule

@@ rtl/mmfc_dp.sv @@
module mmfc_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  mmfc_pkg::req_t  request,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data,
    input  mmfc_pkg::ctl_t  ctl,
    output mmfc_pkg::stat_t stat,
    output mmfc_pkg::rsp_t  result,
    output logic            result_valid
);
    import mmfc_pkg::*;

    req_t                  req_reg;
    logic [7:0]            slave_reg;
    logic [15:0]           addr_reg;
    logic                  wmode_reg;

    logic [15:0]           list_reg [MAX_WORDS];
    logic [LEN_W-1:0]      len_reg;

    logic [7:0]            mem [REPLY_BYTES];
    logic [RX_CNT_W-1:0]   cnt_reg;
    logic [7:0]            rdata_reg;
    logic                  rmask_reg;
    logic                  ok_reg;
    logic [6:0]            n_reg;
    logic [7:0]            hi_reg;

    logic [FRAME_K_W-1:0]  k_reg;
    logic [15:0]           crc_reg;
    rsp_t                  rsp_reg;
    logic                  valid_reg;

    logic                  is_tcp_rx;
    logic [RD_ADDR_W-1:0]  rd_base;
    logic [RD_ADDR_W-1:0]  rd_off;
    logic [RD_ADDR_W-1:0]  rd_addr;
    logic [7:0]            rdata;
    logic [RX_CNT_W-1:0]   min_len;
    logic                  ok_next;

    logic [15:0]           w0;
    logic [7:0]            fn;
    logic [FRAME_K_W-1:0]  wi;
    logic [LIST_IDX_W-1:0] list_idx;
    logic [15:0]           list_word;
    logic [15:0]           plen;
    logic [7:0]            len_byte;
    logic [FRAME_K_W-1:0]  frame_len;
    logic [7:0]            byte_next;
    logic [15:0]           crc_next;
    rsp_t                  rsp_next;
    logic                  frame_last;
    logic                  word_last;
    logic                  list_full;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int j = 0; j < 8; j++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_reg <= 8'd1;
            addr_reg  <= '0;
            wmode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SLAVE_ID:   slave_reg <= cfg_data[7:0];
                CFG_START_ADDR: addr_reg  <= cfg_data;
                CFG_WRITE_MODE: wmode_reg <= cfg_data[0];
                default:        wmode_reg <= wmode_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.req_load)
        begin
            req_reg <= request;
        end
    end

    assign list_full = (len_reg >= LEN_W'(MAX_WORDS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (ctl.list_clear || ctl.dec_start)
        begin
            len_reg <= '0;
        end
        else if ((ctl.list_append || ctl.word_write) && !list_full)
        begin
            len_reg <= len_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.list_append && !list_full)
        begin
            list_reg[len_reg[LIST_IDX_W-1:0]] <= req_reg.value_word;
        end
        else if (ctl.word_write && !list_full)
        begin
            list_reg[len_reg[LIST_IDX_W-1:0]] <= {hi_reg, rdata};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.count_clear)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.rx_write && cnt_reg < RX_CNT_W'(REPLY_BYTES))
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rx_write && cnt_reg < RX_CNT_W'(REPLY_BYTES))
        begin
            mem[cnt_reg[RX_ADDR_W-1:0]] <= req_reg.data_byte;
        end
    end

    assign is_tcp_rx = (cmd_t'(req_reg.command) == CMD_TCP_RX);
    assign rd_base   = is_tcp_rx ? RD_ADDR_W'(TCP_BASE) : '0;
    assign min_len   = is_tcp_rx ? RX_CNT_W'(TCP_MIN_LEN) : RX_CNT_W'(RTU_MIN_LEN);

    always_comb
    begin
        case (ctl.rd_sel)
            RD_FN:   rd_off = RD_ADDR_W'(1);
            RD_BC:   rd_off = RD_ADDR_W'(2);
            RD_HI:   rd_off = RD_ADDR_W'(3) + (RD_ADDR_W'(len_reg) << 1);
            RD_LO:   rd_off = RD_ADDR_W'(4) + (RD_ADDR_W'(len_reg) << 1);
            default: rd_off = '0;
        endcase
    end

    assign rd_addr = rd_base + rd_off;

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_addr[RX_ADDR_W-1:0]];
        rmask_reg <= (rd_addr < RD_ADDR_W'(cnt_reg));
    end

    assign rdata   = rmask_reg ? rdata_reg : 8'h00;
    assign ok_next = (cnt_reg > min_len) && (rdata == FN_READ);

    always_ff @(posedge clk)
    begin
        if (ctl.dec_ok_load)
        begin
            ok_reg <= ok_next;
        end
        if (ctl.dec_start)
        begin
            n_reg <= rdata[7:1];
        end
        if (ctl.hi_load)
        begin
            hi_reg <= rdata;
        end
    end

    assign w0        = (len_reg == '0) ? 16'h0000 : list_reg[0];
    assign fn        = wmode_reg ? FN_WRITE_SINGLE : FN_READ;
    assign wi        = k_reg - FRAME_K_W'(13);
    assign list_idx  = ctl.emit_word ? k_reg[LIST_IDX_W-1:0] : wi[LIST_IDX_W:1];
    assign list_word = list_reg[list_idx];
    assign len_byte  = 8'(len_reg);
    assign plen      = 16'd7 + (16'(len_reg) << 1);

    always_comb
    begin
        byte_next = 8'h00;
        frame_len = FRAME_K_W'(8);
        case (cmd_t'(req_reg.command))
            CMD_RTU_REQ:
            begin
                frame_len = FRAME_K_W'(8);
                case (int'(k_reg))
                    0:       byte_next = slave_reg;
                    1:       byte_next = fn;
                    2:       byte_next = addr_reg[15:8];
                    3:       byte_next = addr_reg[7:0];
                    4:       byte_next = w0[15:8];
                    5:       byte_next = w0[7:0];
                    6:       byte_next = crc_reg[7:0];
                    default: byte_next = crc_reg[15:8];
                endcase
            end
            CMD_TCP_REQ:
            begin
                frame_len = FRAME_K_W'(12);
                case (int'(k_reg))
                    5:       byte_next = 8'd6;
                    6:       byte_next = slave_reg;
                    7:       byte_next = fn;
                    8:       byte_next = addr_reg[15:8];
                    9:       byte_next = addr_reg[7:0];
                    10:      byte_next = w0[15:8];
                    11:      byte_next = w0[7:0];
                    default: byte_next = 8'h00;
                endcase
            end
            default:
            begin
                frame_len = FRAME_K_W'(13) + (FRAME_K_W'(len_reg) << 1);
                case (int'(k_reg))
                    0, 1, 2, 3, 10: byte_next = 8'h00;
                    4:       byte_next = plen[15:8];
                    5:       byte_next = plen[7:0];
                    6:       byte_next = slave_reg;
                    7:       byte_next = FN_WRITE_MULTI;
                    8:       byte_next = addr_reg[15:8];
                    9:       byte_next = addr_reg[7:0];
                    11:      byte_next = len_byte;
                    12:      byte_next = len_byte << 1;
                    default: byte_next = wi[0] ? list_word[7:0] : list_word[15:8];
                endcase
            end
        endcase
    end

    assign frame_last = (k_reg == frame_len - 1'b1);
    assign word_last  = (k_reg == FRAME_K_W'(len_reg) - 1'b1);
    assign crc_next   = crc_byte(crc_reg, byte_next);

    always_ff @(posedge clk)
    begin
        if (ctl.frame_init)
        begin
            k_reg   <= '0;
            crc_reg <= CRC_INIT;
        end
        else if (ctl.frame_emit || ctl.emit_word)
        begin
            k_reg <= k_reg + 1'b1;
            if (k_reg < FRAME_K_W'(6))
            begin
                crc_reg <= crc_next;
            end
        end
    end

    always_comb
    begin
        rsp_next = '0;
        if (ctl.frame_emit)
        begin
            rsp_next.kind       = KIND_BYTE;
            rsp_next.frame_byte = byte_next;
            rsp_next.last       = frame_last;
        end
        else if (ctl.emit_word)
        begin
            rsp_next.kind      = KIND_VALUE;
            rsp_next.reg_value = list_word;
            rsp_next.last      = word_last;
        end
        else
        begin
            rsp_next.kind = KIND_EMPTY;
            rsp_next.last = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctl.frame_emit || ctl.emit_word || ctl.emit_empty;
        end
    end

    assign result       = rsp_reg;
    assign result_valid = valid_reg;

    assign stat.cmd        = req_reg.command;
    assign stat.last_byte  = req_reg.last_byte;
    assign stat.frame_last = frame_last;
    assign stat.dec_more   = ok_reg && (8'(len_reg) < 8'(n_reg)) && !list_full;
    assign stat.list_empty = (len_reg == '0);
    assign stat.word_last  = word_last;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= RX_CNT_W'(REPLY_BYTES))
        else $error("reply byte count beyond buffer size");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_WORDS))
        else $error("word list length beyond capacity");

    a_empty_mark: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit_empty |-> (len_reg == '0))
        else $error("empty mark issued with a non-empty list");

endmodule

@@ rtl/modbus_master_frame_codec_top.sv @@
// Modbus master frame codec. A request is taken when start is high while busy is low; busy then
// stays high until every result of that request has been issued. Results appear one per clock on
// result with result_valid high for exactly one cycle each, and the receiver must take them as
// they come, since there is no way to hold them off. Clear, append and a reply byte that is not
// the last are done in the execute state. A request frame is set up there, then delivered from
// the frame state one byte per cycle: 8 for RTU, 12 for TCP single and 13 plus two per list
// word for TCP multiple. A last reply byte starts a decode that reads the reply buffer through
// its single read port in S_DEC_FN, S_DEC_BC and S_DEC_CHK, then S_DEC_HI, S_DEC_LO and
// S_DEC_WR per word and S_DEC_END; the words then go out one per cycle, or a single empty mark
// when nothing was decoded. Configuration may be written only while busy is low.
module modbus_master_frame_codec_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  mmfc_pkg::req_t request,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [15:0]    cfg_data,
    output mmfc_pkg::rsp_t result,
    output logic           result_valid
);
    import mmfc_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    mmfc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctl   (ctl)
    );

    mmfc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ctl          (ctl),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

@@ verif/modbus_master_frame_codec_top_test.sv @@
module modbus_master_frame_codec_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mmfc_pkg::*;

    localparam int MAX_GAP     = 17;
    localparam int SETTLE      = 64;
    localparam int IDLE_LIMIT  = 4000;
    localparam int PHASE_ITEMS = 12;

    localparam logic [2:0] CMD_UNUSED = 3'd7;

    typedef struct packed {
        req_t item;
        logic fixed;
        rsp_t fixed_out;
    } step_row_t;

    localparam step_row_t DIRECTED_STEPS [27] = '{
        '{'{CMD_RTU_REQ,   16'h0000, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_TCP_REQ,   16'hFFFF, 8'hFF, 1'b1}, 1'b0, '0},
        '{'{CMD_TCP_MULTI, 16'h0000, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_RTU_RX,    16'h0000, 8'h01, 1'b1}, 1'b1, '{KIND_EMPTY, 8'h00, 16'sh0000, 1'b1}},
        '{'{CMD_RTU_RX,    16'h0000, 8'h01, 1'b0}, 1'b0, '0},
        '{'{CMD_RTU_RX,    16'hFFFF, 8'h03, 1'b0}, 1'b0, '0},
        '{'{CMD_RTU_RX,    16'h0000, 8'h02, 1'b0}, 1'b0, '0},
        '{'{CMD_RTU_RX,    16'h0000, 8'h80, 1'b0}, 1'b0, '0},
        '{'{CMD_RTU_RX,    16'h0000, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_RTU_RX,    16'h0000, 8'hB8, 1'b0}, 1'b0, '0},
        '{'{CMD_RTU_RX,    16'h0000, 8'h44, 1'b1}, 1'b1, '{KIND_VALUE, 8'h00, 16'sh8000, 1'b1}},
        '{'{CMD_TCP_REQ,   16'h0000, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_TCP_RX,    16'h0000, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_TCP_RX,    16'h0000, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_TCP_RX,    16'h0000, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_TCP_RX,    16'h0000, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_TCP_RX,    16'h0000, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_TCP_RX,    16'h0000, 8'h25, 1'b0}, 1'b0, '0},
        '{'{CMD_TCP_RX,    16'h0000, 8'h11, 1'b0}, 1'b0, '0},
        '{'{CMD_TCP_RX,    16'h0000, 8'h03, 1'b0}, 1'b0, '0},
        '{'{CMD_TCP_RX,    16'h0000, 8'hFF, 1'b0}, 1'b0, '0},
        '{'{CMD_TCP_RX,    16'h0000, 8'h7F, 1'b1}, 1'b0, '0},
        '{'{CMD_TCP_MULTI, 16'h0000, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_UNUSED,    16'hFFFF, 8'hFF, 1'b1}, 1'b0, '0},
        '{'{CMD_CLEAR,     16'hFFFF, 8'hFF, 1'b1}, 1'b0, '0},
        '{'{CMD_APPEND,    16'hFFFF, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_RTU_REQ,   16'h0000, 8'h00, 1'b0}, 1'b0, '0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    req_t        request = '0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    rsp_t        result;
    logic        result_valid;

    logic [7:0]  slave_reg;
    logic [15:0] addr_reg;
    logic        write_reg;
    logic [15:0] held_words [MAX_WORDS];
    int          held_count;
    logic [7:0]  rx_bytes [REPLY_BYTES];
    int          rx_count;

    rsp_t pending_outputs [$];
    rsp_t step_outputs [$];
    int   mismatches = 0;
    int   idle_cycles = 0;
    int   items_sent = 0;
    bit   start_high = 1'b0;
    bit   no_gaps = 1'b0;

    modbus_master_frame_codec_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result       (result),
        .result_valid (result_valid)
    );

    always #10 clk = ~clk;

    function automatic logic [15:0] crc16_modbus(input logic [7:0] bytes [$]);
        logic [15:0] crc;
        crc = CRC_INIT;
        foreach (bytes[i]) begin
            crc = crc ^ {8'h00, bytes[i]};
            repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

    function automatic logic [7:0] rx_byte_at(input int idx);
        if (idx < rx_count && idx < REPLY_BYTES)
            return rx_bytes[idx];
        return 8'h00;
    endfunction

    task automatic push_out(input kind_t kind, input logic [7:0] b, input logic [15:0] v);
        rsp_t o;
        o.kind = kind;
        o.frame_byte = b;
        o.reg_value = v;
        o.last = 1'b0;
        step_outputs.push_back(o);
    endtask

    task automatic clear_words();
        foreach (held_words[i]) held_words[i] = '0;
        held_count = 0;
    endtask

    task automatic decode_reply(input int base, input int min_len);
        int n;
        clear_words();
        if (rx_count > min_len && rx_byte_at(base + 1) == FN_READ) begin
            n = rx_byte_at(base + 2) / 2;
            for (int i = 0; i < n && held_count < MAX_WORDS; i++) begin
                held_words[held_count] = {rx_byte_at(base + 3 + 2 * i),
                                          rx_byte_at(base + 4 + 2 * i)};
                held_count++;
            end
        end
        if (held_count == 0)
            push_out(KIND_EMPTY, 8'h00, 16'h0000);
        else
            for (int k = 0; k < held_count; k++) push_out(KIND_VALUE, 8'h00, held_words[k]);
    endtask

    task automatic compute_codec_outputs(input req_t r);
        logic [7:0]  fb [$];
        logic [15:0] w0;
        logic [15:0] crc;
        logic [7:0]  fn;
        int          frame_len;
        rsp_t        tail;
        step_outputs.delete();
        w0 = (held_count == 0) ? 16'h0000 : held_words[0];
        fn = write_reg ? FN_WRITE_SINGLE : FN_READ;
        case (r.command)
            CMD_CLEAR: clear_words();
            CMD_APPEND: begin
                if (held_count < MAX_WORDS) begin
                    held_words[held_count] = r.value_word;
                    held_count++;
                end
            end
            CMD_RTU_REQ: begin
                fb = '{slave_reg, fn, addr_reg[15:8], addr_reg[7:0], w0[15:8], w0[7:0]};
                crc = crc16_modbus(fb);
                fb.push_back(crc[7:0]);
                fb.push_back(crc[15:8]);
            end
            CMD_TCP_REQ: begin
                fb = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h06, slave_reg, fn,
                       addr_reg[15:8], addr_reg[7:0], w0[15:8], w0[7:0]};
            end
            CMD_TCP_MULTI: begin
                frame_len = 7 + 2 * held_count;
                fb = '{8'h00, 8'h00, 8'h00, 8'h00, frame_len[15:8], frame_len[7:0], slave_reg,
                       FN_WRITE_MULTI, addr_reg[15:8], addr_reg[7:0], 8'h00,
                       8'(held_count), 8'(2 * held_count)};
                for (int k = 0; k < held_count; k++) begin
                    fb.push_back(held_words[k][15:8]);
                    fb.push_back(held_words[k][7:0]);
                end
            end
            CMD_RTU_RX, CMD_TCP_RX: begin
                if (rx_count < REPLY_BYTES) begin
                    rx_bytes[rx_count] = r.data_byte;
                    rx_count++;
                end
                if (r.last_byte) begin
                    if (r.command == CMD_RTU_RX)
                        decode_reply(0, RTU_MIN_LEN);
                    else
                        decode_reply(TCP_BASE, TCP_MIN_LEN);
                    rx_count = 0;
                end
            end
            default: ;
        endcase
        foreach (fb[i]) push_out(KIND_BYTE, fb[i], 16'h0000);
        if (step_outputs.size() > 0) begin
            tail = step_outputs.pop_back();
            tail.last = 1'b1;
            step_outputs.push_back(tail);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_request(input req_t item, input logic fixed, input rsp_t fixed_out);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0 && start_high) begin
            start <= 1'b0;
            start_high = 1'b0;
        end
        repeat (gap) @(posedge clk);
        request <= item;
        start <= 1'b1;
        start_high = 1'b1;
        do @(posedge clk); while (busy !== 1'b0);
        items_sent++;
        compute_codec_outputs(item);
        if (fixed)
            pending_outputs.push_back(fixed_out);
        else
            foreach (step_outputs[i]) pending_outputs.push_back(step_outputs[i]);
    endtask

    task automatic send_command(input logic [2:0] cmd);
        req_t item;
        item.command = cmd;
        item.value_word = 16'($urandom);
        item.data_byte = 8'($urandom);
        item.last_byte = 1'($urandom);
        send_request(item, 1'b0, '0);
    endtask

    task automatic send_reply(input logic [2:0] cmd, input logic [7:0] bytes [$]);
        req_t item;
        foreach (bytes[i]) begin
            item.command = cmd;
            item.value_word = 16'($urandom);
            item.data_byte = bytes[i];
            item.last_byte = (i == bytes.size() - 1);
            send_request(item, 1'b0, '0);
        end
    endtask

    task automatic drain_codec();
        if (start_high) begin
            start <= 1'b0;
            start_high = 1'b0;
        end
        @(posedge clk);
        while (pending_outputs.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
    endtask

    task automatic load_config(input logic [15:0] slave, input logic [15:0] addr,
                               input logic [15:0] mode);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SLAVE_ID;
        cfg_data <= slave;
        @(posedge clk);
        cfg_index <= CFG_START_ADDR;
        cfg_data <= addr;
        @(posedge clk);
        cfg_index <= CFG_WRITE_MODE;
        cfg_data <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        slave_reg = slave[7:0];
        addr_reg = addr;
        write_reg = mode[0];
    endtask

    task automatic random_phase(input int quota);
        int         first;
        int         n;
        logic [2:0] cmd;
        logic [7:0] fb [$];
        logic [15:0] crc;
        first = items_sent;
        while (items_sent - first < quota) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 18) : $urandom_range(0, 3);
            fb.delete();
            case ($urandom_range(0, 11))
                0: send_command(CMD_CLEAR);
                1, 2: begin
                    n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 20)
                                                     : $urandom_range(1, 4);
                    repeat (n) send_command(CMD_APPEND);
                end
                3: send_command(CMD_RTU_REQ);
                4: send_command(CMD_TCP_REQ);
                5: send_command(CMD_TCP_MULTI);
                6, 7: begin
                    fb = '{8'($urandom), FN_READ, 8'(2 * n)};
                    if ($urandom_range(0, 4) == 0)
                        fb[2] = 8'($urandom);
                    repeat (2 * n) fb.push_back(8'($urandom));
                    crc = crc16_modbus(fb);
                    fb.push_back(crc[7:0]);
                    fb.push_back(crc[15:8]);
                    if ($urandom_range(0, 4) == 0)
                        repeat ($urandom_range(1, 3)) void'(fb.pop_back());
                    send_reply(CMD_RTU_RX, fb);
                end
                8, 9: begin
                    fb = '{8'($urandom), 8'($urandom), 8'h00, 8'h00, 8'h00, 8'(3 + 2 * n),
                           8'($urandom), FN_READ, 8'(2 * n)};
                    if ($urandom_range(0, 4) == 0)
                        fb[8] = 8'($urandom);
                    repeat (2 * n) fb.push_back(8'($urandom));
                    if ($urandom_range(0, 4) == 0)
                        repeat ($urandom_range(1, 3)) void'(fb.pop_back());
                    send_reply(CMD_TCP_RX, fb);
                end
                10: begin
                    cmd = $urandom_range(0, 1) ? CMD_RTU_RX : CMD_TCP_RX;
                    repeat ($urandom_range(1, 12)) fb.push_back(8'($urandom));
                    send_reply(cmd, fb);
                end
                default: send_command(3'($urandom));
            endcase
        end
    endtask

    always @(posedge clk) begin
        rsp_t want;
        if ((start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && result_valid === 1'b1) begin
            if (pending_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d byte %02h value %04h",
                                          result.kind, result.frame_byte, result.reg_value));
            end
            else begin
                want = pending_outputs.pop_front();
                if (result.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d", result.kind, want.kind));
                if (result.frame_byte !== want.frame_byte)
                    report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                              result.frame_byte, want.frame_byte));
                if (result.reg_value !== want.reg_value)
                    report_mismatch($sformatf("reg_value %04h, expected %04h",
                                              result.reg_value, want.reg_value));
                if (result.last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b", result.last, want.last));
            end
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [7:0] fb [$];
        slave_reg = 8'd1;
        addr_reg = 16'h0000;
        write_reg = 1'b0;
        clear_words();
        foreach (rx_bytes[i]) rx_bytes[i] = '0;
        rx_count = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_STEPS[i])
            send_request(DIRECTED_STEPS[i].item, DIRECTED_STEPS[i].fixed,
                         DIRECTED_STEPS[i].fixed_out);
        drain_codec();

        load_config(16'h00FF, 16'hFFFF, 16'h0001);
        random_phase(PHASE_ITEMS);
        drain_codec();

        // A read reply far longer than the buffer; the tail must be dropped.
        load_config(16'h0000, 16'h0000, 16'h0000);
        fb = '{8'h01, FN_READ, 8'hFF};
        repeat (67) fb.push_back(8'($urandom));
        send_reply(CMD_RTU_RX, fb);
        random_phase(PHASE_ITEMS);

        repeat (2) begin
            drain_codec();
            load_config(16'($urandom), 16'($urandom), 16'($urandom));
            random_phase(PHASE_ITEMS);
        end
        drain_codec();

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/mmfc_pkg.sv
rtl/mmfc_ctrl.sv
rtl/mmfc_dp.sv
rtl/modbus_master_frame_codec_top.sv
verif/modbus_master_frame_codec_top_test.sv
